>>> src/tvn_pkg.sv
package tvn_pkg;

  localparam int WORD_W    = 16;
  localparam int COORD_W   = 24;
  localparam int INDEX_W   = 12;
  localparam int CORNERS   = 8;
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 8;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

endpackage

>>> src/tvn_ram.sv
module tvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tvn_fifo.sv
module tvn_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = data_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);

endmodule

>>> src/tvn_front.sv
module tvn_front #(
  parameter int GRID_SIZE     = 16,
  parameter int FRACTION_BITS = 16,
  parameter int MID_W         = 8 * 16 + 3 * 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              op_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_v_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_w_i,
  input  logic [tvn_pkg::INDEX_W-1:0]       cell_index_i,
  input  logic [tvn_pkg::WORD_W-1:0]        cell_value_i,
  input  logic                              mid_pop_i,
  output logic                              full_o,
  output logic                              mid_push_o,
  output logic [MID_W-1:0]                  mid_data_o
);

  localparam int F      = FRACTION_BITS;
  localparam int WW     = tvn_pkg::WORD_W;
  localparam int IDX_W  = $clog2(GRID_SIZE);
  localparam int PW     = F + IDX_W;
  localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(tvn_pkg::MID_DEPTH + 1);

  // Stage A: captured item
  logic              valid_a_q;
  tvn_pkg::op_e      op_a_q;
  logic [F-1:0]      fu_a_q, fv_a_q, fw_a_q;
  logic [tvn_pkg::INDEX_W-1:0] index_a_q;
  logic [WW-1:0]     value_a_q;

  // Stage B: lattice indices and weights, RAM access
  logic              valid_b_q;
  tvn_pkg::op_e      op_b_q;
  logic [IDX_W-1:0]  i0_b_q, j0_b_q, k0_b_q;
  logic [F-1:0]      tu_b_q, tv_b_q, tw_b_q;
  logic [tvn_pkg::INDEX_W-1:0] index_b_q;
  logic [WW-1:0]     value_b_q;

  // Stage C: RAM data out
  logic              valid_c_q;
  logic [F-1:0]      tu_c_q, tv_c_q, tw_c_q;

  logic [PW-1:0]     pu, pv, pw;
  logic [IDX_W-1:0]  i1, j1, k1;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WW-1:0]     rdata [tvn_pkg::CORNERS];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sample_in;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    return (v == IDX_W'(GRID_SIZE - 1)) ? '0 : v + IDX_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y,
                                                   input logic [IDX_W-1:0] z);
    return (ADDR_W'(z) * ADDR_W'(GRID_SIZE) + ADDR_W'(y)) * ADDR_W'(GRID_SIZE)
           + ADDR_W'(x);
  endfunction

  // Outstanding samples: in flight here plus those waiting in the queue.
  assign sample_in = accept_i && (op_i == tvn_pkg::OP_SAMPLE);
  assign cnt_d     = cnt_q + CNT_W'(sample_in) - CNT_W'(mid_pop_i);
  assign full_o    = (cnt_q == CNT_W'(tvn_pkg::MID_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      valid_a_q <= accept_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q && (op_b_q == tvn_pkg::OP_SAMPLE);
    end
  end

  // Only the fraction bits matter: the coordinate wraps modulo 1.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_a_q    <= tvn_pkg::op_e'(op_i);
      fu_a_q    <= coord_u_i[F-1:0];
      fv_a_q    <= coord_v_i[F-1:0];
      fw_a_q    <= coord_w_i[F-1:0];
      index_a_q <= cell_index_i;
      value_a_q <= cell_value_i;
    end
  end

  assign pu = PW'(fu_a_q) * PW'(GRID_SIZE);
  assign pv = PW'(fv_a_q) * PW'(GRID_SIZE);
  assign pw = PW'(fw_a_q) * PW'(GRID_SIZE);

  always_ff @(posedge clk_i) begin
    op_b_q    <= op_a_q;
    i0_b_q    <= pu[PW-1:F];
    j0_b_q    <= pv[PW-1:F];
    k0_b_q    <= pw[PW-1:F];
    tu_b_q    <= pu[F-1:0];
    tv_b_q    <= pv[F-1:0];
    tw_b_q    <= pw[F-1:0];
    index_b_q <= index_a_q;
    value_b_q <= value_a_q;
  end

  assign i1 = wrap_inc(i0_b_q);
  assign j1 = wrap_inc(j0_b_q);
  assign k1 = wrap_inc(k0_b_q);

  // Writes beyond the lattice are dropped.
  assign we    = valid_b_q && (op_b_q == tvn_pkg::OP_WRITE)
                 && (32'(index_b_q) < CELLS);
  assign waddr = ADDR_W'(index_b_q);

  // One lattice copy per corner; corner bit 0 picks x+1, bit 1 y+1, bit 2 z+1.
  for (genvar c = 0; c < tvn_pkg::CORNERS; c++) begin : g_corner
    logic [ADDR_W-1:0] raddr;

    assign raddr = cell_addr((c % 2 == 1) ? i1 : i0_b_q,
                             ((c / 2) % 2 == 1) ? j1 : j0_b_q,
                             (c / 4 == 1) ? k1 : k0_b_q);

    tvn_ram #(
      .WIDTH(WW),
      .DEPTH(CELLS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(value_b_q),
      .raddr_i(raddr),
      .rdata_o(rdata[c])
    );

    assign mid_data_o[c*WW +: WW] = rdata[c];
  end

  always_ff @(posedge clk_i) begin
    tu_c_q <= tu_b_q;
    tv_c_q <= tv_b_q;
    tw_c_q <= tw_b_q;
  end

  assign mid_push_o = valid_c_q;
  assign mid_data_o[tvn_pkg::CORNERS*WW +: F]       = tu_c_q;
  assign mid_data_o[tvn_pkg::CORNERS*WW + F +: F]   = tv_c_q;
  assign mid_data_o[tvn_pkg::CORNERS*WW + 2*F +: F] = tw_c_q;

endmodule

>>> src/tvn_back.sv
module tvn_back #(
  parameter int FRACTION_BITS = 16,
  parameter int MID_W         = 8 * 16 + 3 * 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          mid_empty_i,
  input  logic [MID_W-1:0]              mid_data_i,
  output logic                          mid_pop_o,
  input  logic                          out_pop_i,
  output logic                          out_push_o,
  output logic [tvn_pkg::WORD_W-1:0]    out_data_o
);

  localparam int F     = FRACTION_BITS;
  localparam int WW    = tvn_pkg::WORD_W;
  localparam int PRW   = WW + F + 2;
  localparam int CNT_W = $clog2(tvn_pkg::OUT_DEPTH + 1);
  localparam int TB    = tvn_pkg::CORNERS * WW;

  logic             valid_s1_q, valid_s2_q;
  logic [WW-1:0]    e_q [4];
  logic [F-1:0]     tv_s1_q, tw_s1_q, tw_s2_q;
  logic [WW-1:0]    f_q [2];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [F-1:0]     tu_in, tv_in, tw_in;

  // c0 + round_half_up((c1 - c0) * t / 2^F), clamped to a word
  function automatic logic [WW-1:0] lerp(input logic [WW-1:0] c0,
                                         input logic [WW-1:0] c1,
                                         input logic [F-1:0]  t);
    logic signed [WW:0]    diff;
    logic signed [PRW-1:0] prod;
    logic signed [PRW-1:0] acc;
    logic signed [PRW-1:0] res;
    diff = $signed({1'b0, c1}) - $signed({1'b0, c0});
    prod = diff * $signed({1'b0, t});
    acc  = prod + $signed(PRW'(1) << (F - 1));
    res  = (acc >>> F) + $signed(PRW'(c0));
    if (res < 0) begin
      return '0;
    end else if (res > $signed(PRW'({WW{1'b1}}))) begin
      return '1;
    end
    return res[WW-1:0];
  endfunction

  // Outstanding results: in the blend stages plus waiting at the output.
  assign mid_pop_o = !mid_empty_i && (cnt_q < CNT_W'(tvn_pkg::OUT_DEPTH));
  assign cnt_d     = cnt_q + CNT_W'(mid_pop_o) - CNT_W'(out_pop_i);

  assign tu_in = mid_data_i[TB +: F];
  assign tv_in = mid_data_i[TB + F +: F];
  assign tw_in = mid_data_i[TB + 2*F +: F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      valid_s1_q <= mid_pop_o;
      valid_s2_q <= valid_s1_q;
    end
  end

  // x edges: corner pairs differ only in bit 0
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 4; e++) begin
      e_q[e] <= lerp(mid_data_i[(2*e)*WW +: WW], mid_data_i[(2*e+1)*WW +: WW], tu_in);
    end
    tv_s1_q <= tv_in;
    tw_s1_q <= tw_in;
  end

  // y blend, e_q index bit 0 is y, bit 1 is z
  always_ff @(posedge clk_i) begin
    f_q[0]  <= lerp(e_q[0], e_q[1], tv_s1_q);
    f_q[1]  <= lerp(e_q[2], e_q[3], tv_s1_q);
    tw_s2_q <= tw_s1_q;
  end

  assign out_push_o = valid_s2_q;
  assign out_data_o = lerp(f_q[0], f_q[1], tw_s2_q);

endmodule

>>> src/trilinear_value_noise_3d.sv
// Periodic 3D value-noise sampler. A write item (op 0) stores cell_value at
// cell_index of a GRID_SIZE^3 lattice; indexes beyond the lattice are dropped.
// A sample item (op 1) wraps each coordinate modulo 1, fetches the eight
// surrounding lattice words with wrap-around and returns one trilinear blend.
// One item is accepted per cycle while full is low; a sample's result passes
// through three front stages with the lattice read, the queue, two blend
// stages and the output queue. Full rises only when eight samples are
// outstanding in the front stages and the queue ahead of the blend stages.
// The lattice is held in eight copies, one per corner, so every corner has
// its own read port; each write goes to all copies. Reading a never-written
// cell is undefined.
module trilinear_value_noise_3d #(
  parameter int GRID_SIZE     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               op_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_v_i,
  input  logic signed [tvn_pkg::COORD_W-1:0] coord_w_i,
  input  logic [tvn_pkg::INDEX_W-1:0]        cell_index_i,
  input  logic [tvn_pkg::WORD_W-1:0]         cell_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [tvn_pkg::WORD_W-1:0]         noise_value_o
);

  localparam int MID_W = tvn_pkg::CORNERS * tvn_pkg::WORD_W + 3 * FRACTION_BITS;

  logic                       accept;
  logic                       out_pop;
  logic                       mid_push, mid_pop, mid_empty;
  logic [MID_W-1:0]           mid_wdata, mid_rdata;
  logic                       out_push;
  logic [tvn_pkg::WORD_W-1:0] out_wdata;

  assign accept  = push && !full;
  assign out_pop = pop && !empty;

  tvn_front #(
    .GRID_SIZE    (GRID_SIZE),
    .FRACTION_BITS(FRACTION_BITS),
    .MID_W        (MID_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .coord_u_i   (coord_u_i),
    .coord_v_i   (coord_v_i),
    .coord_w_i   (coord_w_i),
    .cell_index_i(cell_index_i),
    .cell_value_i(cell_value_i),
    .mid_pop_i   (mid_pop),
    .full_o      (full),
    .mid_push_o  (mid_push),
    .mid_data_o  (mid_wdata)
  );

  tvn_fifo #(
    .WIDTH(MID_W),
    .DEPTH(tvn_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(mid_wdata),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  tvn_back #(
    .FRACTION_BITS(FRACTION_BITS),
    .MID_W        (MID_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty),
    .mid_data_i (mid_rdata),
    .mid_pop_o  (mid_pop),
    .out_pop_i  (out_pop),
    .out_push_o (out_push),
    .out_data_o (out_wdata)
  );

  tvn_fifo #(
    .WIDTH(tvn_pkg::WORD_W),
    .DEPTH(tvn_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .pop_i  (out_pop),
    .rdata_o(noise_value_o),
    .empty_o(empty)
  );

endmodule

>>> verif/tb_trilinear_value_noise_3d.sv
`timescale 1ns / 1ps

module tb_trilinear_value_noise_3d;

  localparam int GRID  = 16;
  localparam int FRAC  = 16;
  localparam int CELLS = GRID * GRID * GRID;
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC) - 64'd1;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               push;
  logic                               full;
  logic                               op_i;
  logic signed [tvn_pkg::COORD_W-1:0] coord_u_i;
  logic signed [tvn_pkg::COORD_W-1:0] coord_v_i;
  logic signed [tvn_pkg::COORD_W-1:0] coord_w_i;
  logic [tvn_pkg::INDEX_W-1:0]        cell_index_i;
  logic [tvn_pkg::WORD_W-1:0]         cell_value_i;
  logic                               empty;
  logic                               pop;
  logic [tvn_pkg::WORD_W-1:0]         noise_value_o;

  // mirror of the lattice and which cells hold a known word
  logic [tvn_pkg::WORD_W-1:0] lattice_mirror [CELLS];
  bit                         cell_loaded [CELLS];
  logic [tvn_pkg::WORD_W-1:0] noise_expect_q [$];
  int                         err_count;
  bit                         calm;
  int                         pop_hold;

  trilinear_value_noise_3d #(
    .GRID_SIZE     (GRID),
    .FRACTION_BITS (FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .coord_w_i     (coord_w_i),
    .cell_index_i  (cell_index_i),
    .cell_value_i  (cell_value_i),
    .empty         (empty),
    .pop           (pop),
    .noise_value_o (noise_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [tvn_pkg::WORD_W-1:0] mix_pair(input longint unsigned c0,
                                                          input longint unsigned c1,
                                                          input longint unsigned t);
    longint unsigned one;
    longint unsigned acc;
    one = 64'd1 << FRAC;
    acc = (c0 * (one - t) + c1 * t + (one >> 1)) >> FRAC;
    return (acc > 64'd65535) ? 16'hFFFF : acc[tvn_pkg::WORD_W-1:0];
  endfunction

  function automatic void split_axis(input logic [tvn_pkg::COORD_W-1:0] raw,
                                     output int unsigned idx,
                                     output longint unsigned wt);
    longint unsigned p;
    p   = (longint'(raw) & FRAC_MASK) * GRID;
    idx = int'((p >> FRAC) % GRID);
    wt  = p & FRAC_MASK;
  endfunction

  function automatic int unsigned cell_addr(input int unsigned x, input int unsigned y,
                                            input int unsigned z);
    return (z * GRID + y) * GRID + x;
  endfunction

  function automatic longint unsigned cell_word(input int unsigned x, input int unsigned y,
                                                input int unsigned z);
    int unsigned a;
    a = cell_addr(x, y, z);
    return (a < CELLS) ? longint'(lattice_mirror[a]) : 64'd0;
  endfunction

  function automatic logic [tvn_pkg::WORD_W-1:0] blend_noise(
      input logic [tvn_pkg::COORD_W-1:0] u,
      input logic [tvn_pkg::COORD_W-1:0] v,
      input logic [tvn_pkg::COORD_W-1:0] w);
    int unsigned     x0, x1, y0, y1, z0, z1;
    longint unsigned tu, tv, tw;
    logic [tvn_pkg::WORD_W-1:0] e00, e10, e01, e11, f0, f1;
    split_axis(u, x0, tu);
    split_axis(v, y0, tv);
    split_axis(w, z0, tw);
    x1 = (x0 + 1) % GRID;
    y1 = (y0 + 1) % GRID;
    z1 = (z0 + 1) % GRID;
    e00 = mix_pair(cell_word(x0, y0, z0), cell_word(x1, y0, z0), tu);
    e10 = mix_pair(cell_word(x0, y1, z0), cell_word(x1, y1, z0), tu);
    e01 = mix_pair(cell_word(x0, y0, z1), cell_word(x1, y0, z1), tu);
    e11 = mix_pair(cell_word(x0, y1, z1), cell_word(x1, y1, z1), tu);
    f0  = mix_pair(64'(e00), 64'(e10), tv);
    f1  = mix_pair(64'(e01), 64'(e11), tv);
    return mix_pair(64'(f0), 64'(f1), tw);
  endfunction

  // drive one item, hold until accepted, then update the mirror or queue the expected result
  task automatic push_item(input tvn_pkg::op_e op, input logic [tvn_pkg::COORD_W-1:0] u,
                           input logic [tvn_pkg::COORD_W-1:0] v,
                           input logic [tvn_pkg::COORD_W-1:0] w,
                           input logic [tvn_pkg::INDEX_W-1:0] idx,
                           input logic [tvn_pkg::WORD_W-1:0] val);
    int gap;
    if (!calm && $urandom_range(99) < 10) begin
      gap = ($urandom_range(19) == 0) ? $urandom_range(12, 2) : 1;
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    op_i         <= op;
    coord_u_i    <= u;
    coord_v_i    <= v;
    coord_w_i    <= w;
    cell_index_i <= idx;
    cell_value_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (op == tvn_pkg::OP_WRITE) begin
      if (int'(idx) < CELLS) begin
        lattice_mirror[idx] = val;
        cell_loaded[idx]    = 1'b1;
      end
    end else begin
      noise_expect_q = {noise_expect_q, blend_noise(u, v, w)};
    end
  endtask

  task automatic write_cell(input int unsigned addr, input logic [tvn_pkg::WORD_W-1:0] val);
    push_item(tvn_pkg::OP_WRITE, 24'($urandom), 24'($urandom), 24'($urandom),
              addr[tvn_pkg::INDEX_W-1:0], val);
  endtask

  // loads any of the eight corners not yet known, then samples
  task automatic sample_at(input logic [tvn_pkg::COORD_W-1:0] u,
                           input logic [tvn_pkg::COORD_W-1:0] v,
                           input logic [tvn_pkg::COORD_W-1:0] w);
    int unsigned     xs[2], ys[2], zs[2];
    int unsigned     addr;
    longint unsigned wt;
    split_axis(u, xs[0], wt);
    split_axis(v, ys[0], wt);
    split_axis(w, zs[0], wt);
    xs[1] = (xs[0] + 1) % GRID;
    ys[1] = (ys[0] + 1) % GRID;
    zs[1] = (zs[0] + 1) % GRID;
    for (int c = 0; c < 8; c++) begin
      addr = cell_addr(xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1]);
      if (!cell_loaded[addr]) write_cell(addr, 16'($urandom));
    end
    push_item(tvn_pkg::OP_SAMPLE, u, v, w, 12'($urandom), 16'($urandom));
  endtask

  // result side: random stalls, compare each popped word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (noise_expect_q.size() == 0) begin
          $error("noise_value: unexpected result, actual %0d", noise_value_o);
          err_count++;
        end else if (noise_expect_q[0] !== noise_value_o) begin
          $error("noise_value: expected %0d, actual %0d", noise_expect_q[0], noise_value_o);
          err_count++;
          void'(noise_expect_q.pop_front());
        end else begin
          void'(noise_expect_q.pop_front());
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(99) < 7) begin
        pop_hold = ($urandom_range(19) == 0) ? $urandom_range(30) : 0;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // corners of the top cell wrap to index 0 on every axis
  task automatic test_wrap_extremes();
    for (int c = 0; c < 8; c++)
      write_cell(cell_addr((c & 1) ? 0 : 15, (c & 2) ? 0 : 15, (c & 4) ? 0 : 15), 16'hFFFF);
    sample_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    sample_at(24'h7FFFFF, 24'hFFF000, 24'hFFFFFF);
    sample_at(24'hFFF000, 24'hFFF000, 24'hFFF000);
  endtask

  task automatic test_write_then_sample();
    write_cell(cell_addr(15, 15, 15), 16'h0000);
    sample_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    // -0.25, most negative, and one half
    sample_at(24'hFFC000, 24'h800000, 24'h008000);
  endtask

  // x and y sweep the whole lattice; z stays in the slab across the wrap seam
  task automatic test_random_traffic(input int count);
    int sel;
    logic [tvn_pkg::COORD_W-1:0] w_coord;
    for (int n = 0; n < count; n++) begin
      sel     = $urandom_range(99);
      w_coord = {8'($urandom), {4{1'($urandom)}}, 12'($urandom)};
      if (sel < 30)
        write_cell($urandom_range(CELLS - 1), 16'($urandom));
      else if (sel < 40)
        // exact lattice points in x and y, zero weights on those axes
        sample_at(24'($urandom) & 24'hFFF000, 24'($urandom) & 24'hFFF000, w_coord);
      else
        sample_at(24'($urandom), 24'($urandom), w_coord);
    end
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random_traffic(count);
    calm = 1'b0;
  endtask

  initial begin
    err_count    = 0;
    calm         = 1'b0;
    pop_hold     = 0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    op_i         = tvn_pkg::OP_WRITE;
    coord_u_i    = '0;
    coord_v_i    = '0;
    coord_w_i    = '0;
    cell_index_i = '0;
    cell_value_i = '0;
    for (int a = 0; a < CELLS; a++) begin
      lattice_mirror[a] = '0;
      cell_loaded[a]    = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wrap_extremes();
    test_write_then_sample();
    test_random_traffic(800);
    test_back_to_back(400);

    push <= 1'b0;
    for (int k = 0; k < 20000 && noise_expect_q.size() != 0; k++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (noise_expect_q.size() != 0) begin
      $error("noise_value: %0d results never arrived", noise_expect_q.size());
      err_count++;
    end
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
